[rtl/htfc_pkg.sv]
// shared types, constants and crc functions for the humidity/temperature frame checker
package htfc_pkg;

    localparam int TempW     = 16;
    localparam int HumW      = 7;
    localparam int StatusW   = 2;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 12;
    localparam int LimitW    = 8;
    localparam int TempDltW  = 8;
    localparam int IntervalW = 12;
    localparam int ElapsedW  = 16;

    localparam logic signed [TempW-1:0] InvalidTemp = -16'sd27315;
    localparam logic [7:0]  CrcPoly        = 8'h31;
    localparam logic [7:0]  CrcInit        = 8'hFF;
    localparam logic [14:0] TempScale      = 15'd17500;
    localparam logic [16:0] TempOffset     = 17'd4500;
    localparam logic [6:0]  HumScale       = 7'd100;
    localparam logic [3:0]  TempDeltaScale = 4'd10;

    localparam logic [TempDltW-1:0]  RstMinTempDelta = 8'd5;
    localparam logic [HumW-1:0]      RstMinHumDelta  = 7'd2;
    localparam logic [IntervalW-1:0] RstMaxInterval  = 12'd150;
    localparam logic [IntervalW-1:0] RstMinInterval  = 12'd10;
    localparam logic [LimitW-1:0]    RstErrorLimit   = 8'd10;

    typedef enum logic [CfgAddrW-1:0] {
        REG_MIN_TEMP_DELTA = 3'd0,
        REG_MIN_HUM_DELTA  = 3'd1,
        REG_MAX_INTERVAL   = 3'd2,
        REG_MIN_INTERVAL   = 3'd3,
        REG_ERROR_LIMIT    = 3'd4
    } cfg_reg_t;

    typedef enum logic [StatusW-1:0] {
        STATUS_GOOD      = 2'd0,
        STATUS_READ_FAIL = 2'd1,
        STATUS_TEMP_CRC  = 2'd2,
        STATUS_HUM_CRC   = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic                read_ok;
        logic [7:0]          temp_msb;
        logic [7:0]          temp_lsb;
        logic [7:0]          temp_crc;
        logic [7:0]          hum_msb;
        logic [7:0]          hum_lsb;
        logic [7:0]          hum_crc;
        logic [ElapsedW-1:0] elapsed_s;
    } frame_t;

    typedef struct packed {
        logic                    temp_ok;
        logic                    hum_ok;
        logic signed [TempW-1:0] temp;
        logic [HumW-1:0]         hum;
    } decode_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_byte(crc8_byte(CrcInit, hi), lo);
    endfunction

endpackage

[rtl/htfc_decode.sv]
// crc check and unit conversion of one sensor frame
module htfc_decode (
    input  htfc_pkg::frame_t  frame,
    output htfc_pkg::decode_t dec
);
    import htfc_pkg::*;

    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic [30:0] temp_prod;
    logic [22:0] hum_prod;
    logic signed [16:0] temp_conv;

    assign temp_raw  = {frame.temp_msb, frame.temp_lsb};
    assign hum_raw   = {frame.hum_msb, frame.hum_lsb};
    assign temp_prod = 31'(TempScale) * 31'(temp_raw);
    assign hum_prod  = 23'(HumScale) * 23'(hum_raw);
    assign temp_conv = $signed({2'b00, temp_prod[30:16]}) - $signed(TempOffset);

    assign dec.temp_ok = frame.read_ok
                         && (crc8_word(frame.temp_msb, frame.temp_lsb) == frame.temp_crc);
    assign dec.hum_ok  = dec.temp_ok
                         && (crc8_word(frame.hum_msb, frame.hum_lsb) == frame.hum_crc);
    assign dec.temp    = TempW'(temp_conv);
    assign dec.hum     = hum_prod[22:16];

endmodule

[rtl/humidity_temp_frame_check_report.sv]
// top level: frame check, failure counter and report decision for a humidity/temperature sensor
//
//  channel   ports            word contents
//  input     s_t*             one sensor read attempt
//  result    m_t*             current values, frame status, report and reset flags
//  config    cfg_*            register writes, index 0..4
//
//  one word per cycle sustained while m_tready holds; input register, then result register
//  the decode multiplier and the report compare sit between the two registers
//  aresetn is synchronous: config and state registers load their defaults, valid flags clear, state goes invalid
//  a stalled result holds; the input side keeps taking words until both registers are full
module humidity_temp_frame_check_report (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // temp_msb, temp_lsb, temp_crc, hum_msb, hum_lsb, hum_crc, elapsed_s
    input  logic [63:0]                     s_tdata,
    // read_ok
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // centi_celsius, humidity_pct, report, sensor_reset
    output logic [31:0]                     m_tdata,
    // frame_status
    output logic [htfc_pkg::StatusW-1:0]    m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [htfc_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [htfc_pkg::CfgDataW-1:0]   cfg_wdata
);
    import htfc_pkg::*;

    logic [TempDltW-1:0]  min_temp_delta_reg;
    logic [HumW-1:0]      min_hum_delta_reg;
    logic [IntervalW-1:0] max_interval_reg;
    logic [IntervalW-1:0] min_interval_reg;
    logic [LimitW-1:0]    error_limit_reg;

    logic   in_valid_reg;
    frame_t in_frame_reg;
    logic   advance;

    logic signed [TempW-1:0] cur_temp_reg, cur_temp_next;
    logic [HumW-1:0]         cur_hum_reg, cur_hum_next;
    logic signed [TempW-1:0] sent_temp_reg, sent_temp_next;
    logic [HumW-1:0]         sent_hum_reg, sent_hum_next;
    logic [LimitW-1:0]       fail_count_reg, fail_count_next;

    logic                    out_valid_reg;
    logic signed [TempW-1:0] out_temp_reg;
    logic [HumW-1:0]         out_hum_reg;
    frame_status_t           out_status_reg;
    logic                    out_report_reg;
    logic                    out_rst_reg;

    decode_t         dec;
    frame_status_t   status;
    logic            exhaust;
    logic            evaluate;
    logic [IntervalW-1:0] gap;
    logic            interval_hit;
    logic [HumW-1:0] hum_diff;
    logic            hum_hit;
    logic signed [16:0] temp_diff;
    logic [16:0]     temp_abs;
    logic [11:0]     temp_thresh;
    logic            temp_hit;
    logic            report_now;

    htfc_decode u_decode (
        .frame (in_frame_reg),
        .dec   (dec)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_temp_delta_reg <= RstMinTempDelta;
            min_hum_delta_reg  <= RstMinHumDelta;
            max_interval_reg   <= RstMaxInterval;
            min_interval_reg   <= RstMinInterval;
            error_limit_reg    <= RstErrorLimit;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MIN_TEMP_DELTA: min_temp_delta_reg <= cfg_wdata[TempDltW-1:0];
                REG_MIN_HUM_DELTA:  min_hum_delta_reg  <= cfg_wdata[HumW-1:0];
                REG_MAX_INTERVAL:   max_interval_reg   <= cfg_wdata[IntervalW-1:0];
                REG_MIN_INTERVAL:   min_interval_reg   <= cfg_wdata[IntervalW-1:0];
                REG_ERROR_LIMIT:    error_limit_reg    <= cfg_wdata[LimitW-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_frame_reg <= {s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                             s_tdata[31:24], s_tdata[39:32], s_tdata[47:40], s_tdata[63:48]};
        end
    end

    always_comb begin
        if (!in_frame_reg.read_ok) begin
            status = STATUS_READ_FAIL;
        end else if (!dec.temp_ok) begin
            status = STATUS_TEMP_CRC;
        end else if (!dec.hum_ok) begin
            status = STATUS_HUM_CRC;
        end else begin
            status = STATUS_GOOD;
        end
    end

    assign exhaust  = (status != STATUS_GOOD) && (fail_count_reg <= LimitW'(1));
    assign evaluate = (status == STATUS_GOOD) || exhaust;

    always_comb begin
        cur_temp_next = dec.temp_ok ? dec.temp : cur_temp_reg;
        cur_hum_next  = dec.hum_ok ? dec.hum : cur_hum_reg;
        if (exhaust) begin
            cur_temp_next = InvalidTemp;
            cur_hum_next  = '0;
        end
    end

    // report rules
    assign gap          = (max_interval_reg > min_interval_reg)
                          ? (max_interval_reg - min_interval_reg) : '0;
    assign interval_hit = (max_interval_reg != '0)
                          && (in_frame_reg.elapsed_s >= ElapsedW'(gap));

    assign hum_diff = (cur_hum_next >= sent_hum_reg) ? (cur_hum_next - sent_hum_reg)
                                                     : (sent_hum_reg - cur_hum_next);
    assign hum_hit  = (min_hum_delta_reg != '0) && (hum_diff >= min_hum_delta_reg);

    assign temp_diff   = 17'(cur_temp_next) - 17'(sent_temp_reg);
    assign temp_abs    = temp_diff[16] ? 17'(-temp_diff) : 17'(temp_diff);
    assign temp_thresh = 12'(min_temp_delta_reg) * 12'(TempDeltaScale);
    assign temp_hit    = (min_temp_delta_reg != '0) && (temp_abs >= 17'(temp_thresh));

    assign report_now = evaluate && (interval_hit || hum_hit || temp_hit);

    assign sent_temp_next  = report_now ? cur_temp_next : sent_temp_reg;
    assign sent_hum_next   = report_now ? cur_hum_next : sent_hum_reg;
    assign fail_count_next = evaluate ? error_limit_reg : fail_count_reg - LimitW'(1);

    // sensor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_temp_reg   <= InvalidTemp;
            cur_hum_reg    <= '0;
            sent_temp_reg  <= InvalidTemp;
            sent_hum_reg   <= '0;
            fail_count_reg <= RstErrorLimit;
        end else if (advance) begin
            cur_temp_reg   <= cur_temp_next;
            cur_hum_reg    <= cur_hum_next;
            sent_temp_reg  <= sent_temp_next;
            sent_hum_reg   <= sent_hum_next;
            fail_count_reg <= fail_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_temp_reg   <= cur_temp_next;
            out_hum_reg    <= cur_hum_next;
            out_status_reg <= status;
            out_report_reg <= report_now;
            out_rst_reg    <= exhaust;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_rst_reg, out_report_reg, out_hum_reg, out_temp_reg};
    assign m_tuser  = out_status_reg;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a register was free");

    a_reset_invalidates: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rst_reg) |-> (out_temp_reg == InvalidTemp && out_hum_reg == '0))
        else $error("sensor reset word without invalid values");

    a_good_no_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_GOOD) |-> !out_rst_reg)
        else $error("sensor reset on a good frame");

    a_fail_count_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !evaluate) |=> (fail_count_reg == $past(fail_count_reg) - LimitW'(1)))
        else $error("failure counter did not step down");

    a_sent_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !report_now) |=> $stable(sent_temp_reg) && $stable(sent_hum_reg))
        else $error("last-sent values moved without a report");

endmodule
